@@ hdl/crc8df_pkg.sv @@
// Package with shared types, codes and the CRC-8 byte update for the CRC-8 frame deframer.
`timescale 1ns / 1ps

package crc8df_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned StatusWidth = 3;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned RspDataWidth = 40;

   localparam logic [ByteWidth-1:0] HeaderFirstReset  = 8'h77;
   localparam logic [ByteWidth-1:0] HeaderSecondReset = 8'h88;
   localparam logic [ByteWidth-1:0] TrailerReset      = 8'h0D;
   localparam logic [ByteWidth-1:0] CodeRequestReset  = 8'hA1;
   localparam logic [ByteWidth-1:0] CodeCommandReset  = 8'h18;
   localparam logic [ByteWidth-1:0] CrcPolyReset      = 8'h07;

   localparam logic [ByteWidth-1:0] PosHeaderFirst  = 8'd0;
   localparam logic [ByteWidth-1:0] PosHeaderSecond = 8'd1;
   localparam logic [ByteWidth-1:0] PosCode         = 8'd2;
   localparam logic [ByteWidth-1:0] PosLength       = 8'd3;
   localparam logic [ByteWidth-1:0] PosPayload      = 8'd4;
   localparam logic [ByteWidth-1:0] PosMax          = 8'hFF;
   localparam logic [ByteWidth:0]   MinFrameBytes   = 9'd6;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_HEADER_FIRST  = 3'd0,
      CSR_HEADER_SECOND = 3'd1,
      CSR_TRAILER       = 3'd2,
      CSR_CODE_REQUEST  = 3'd3,
      CSR_CODE_COMMAND  = 3'd4,
      CSR_CRC_POLY      = 3'd5
   } csr_index_type;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK      = 3'd0,
      STATUS_SHORT   = 3'd1,
      STATUS_HEADER  = 3'd2,
      STATUS_CODE    = 3'd3,
      STATUS_LENGTH  = 3'd4,
      STATUS_TRAILER = 3'd5,
      STATUS_CRC     = 3'd6
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   function automatic logic [ByteWidth-1:0] crc8_feed(
      input logic [ByteWidth-1:0] crc,
      input logic [ByteWidth-1:0] data,
      input logic [ByteWidth-1:0] poly
   );
      logic [ByteWidth-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < ByteWidth; k++) begin
         if (c[ByteWidth-1]) begin
            c = {c[ByteWidth-2:0], 1'b0} ^ poly;
         end else begin
            c = {c[ByteWidth-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ hdl/crc8_frame_deframer.sv @@
// CRC-8 frame deframer: header, code and length checks, payload output and end-of-frame status.
`timescale 1ns / 1ps

// Takes one received byte per transaction on the req_ side, with req_tlast on the final byte
// of a frame, and gives at most one transaction on the rsp_ side for it: a payload byte
// (rsp_tuser low) for each of the bytes after the length byte, up to the declared length, and
// a status (rsp_tuser high) for the byte marked last, after which a new frame starts. The
// CRC-8 update is a fully unrolled eight-step shift over one byte, so a byte is accepted
// every cycle while rsp_tready is high or the result register is empty,
// and its result appears in the result register on the next cycle. Configuration writes on
// the csr_ port take effect at once and are meant to be made while no frame is in progress.
module crc8_frame_deframer
   import crc8df_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [ByteWidth-1:0]      req_tdata,   // [7:0] in_byte
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [7:0] payload_byte, [15:8] payload_index, [23:16] frame_code,
   // [31:24] frame_length, [34:32] status, [39:35] zero
   output logic [RspDataWidth-1:0]   rsp_tdata,
   output logic                      rsp_tuser,   // [0] kind
   input  logic                      csr_wen,
   input  logic [CsrAddrWidth-1:0]   csr_addr,
   input  logic [ByteWidth-1:0]      csr_wdata
);

   logic [ByteWidth-1:0] header_first_ff, header_second_ff, trailer_ff;
   logic [ByteWidth-1:0] code_request_ff, code_command_ff, crc_poly_ff;

   logic [ByteWidth-1:0] position_ff, position_in;
   logic [ByteWidth-1:0] crc_ff, crc_in;
   logic [ByteWidth-1:0] code_ff, code_in;
   logic [ByteWidth-1:0] length_ff, length_in;
   logic [ByteWidth-1:0] crc_rx_ff, crc_rx_in;
   logic                 header_err_ff, header_err_in;
   logic                 code_err_ff, code_err_in;
   logic                 overflow_ff, overflow_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [RspDataWidth-1:0] rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 over;
   logic                 emit;
   logic [ByteWidth-1:0] idx;
   logic [ByteWidth-1:0] crc_fed;
   logic [ByteWidth:0]   byte_count;
   logic [ByteWidth:0]   expected_count;
   status_type           status;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HeaderFirstReset;
         header_second_ff <= HeaderSecondReset;
         trailer_ff       <= TrailerReset;
         code_request_ff  <= CodeRequestReset;
         code_command_ff  <= CodeCommandReset;
         crc_poly_ff      <= CrcPolyReset;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_HEADER_FIRST:  header_first_ff  <= csr_wdata;
            CSR_HEADER_SECOND: header_second_ff <= csr_wdata;
            CSR_TRAILER:       trailer_ff       <= csr_wdata;
            CSR_CODE_REQUEST:  code_request_ff  <= csr_wdata;
            CSR_CODE_COMMAND:  code_command_ff  <= csr_wdata;
            CSR_CRC_POLY:      crc_poly_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      position_in   = position_ff;
      crc_in        = crc_ff;
      code_in       = code_ff;
      length_in     = length_ff;
      crc_rx_in     = crc_rx_ff;
      header_err_in = header_err_ff;
      code_err_in   = code_err_ff;
      overflow_in   = overflow_ff;
      emit          = 1'b0;
      idx           = '0;
      status        = STATUS_OK;
      over          = overflow_ff || (position_ff == PosMax);
      crc_fed       = crc8_feed(crc_ff, req_tdata, crc_poly_ff);

      if (!over) begin
         if (position_ff == PosHeaderFirst && req_tdata != header_first_ff) begin
            header_err_in = 1'b1;
         end
         if (position_ff == PosHeaderSecond && req_tdata != header_second_ff) begin
            header_err_in = 1'b1;
         end
         if (position_ff == PosCode) begin
            code_in = req_tdata;
            if (req_tdata != code_request_ff && req_tdata != code_command_ff) begin
               code_err_in = 1'b1;
            end
         end
         if (position_ff == PosLength) begin
            length_in = req_tdata;
         end
         if (position_ff < PosPayload) begin
            crc_in = crc_fed;
         end else begin
            idx = position_ff - PosPayload;
            if (idx < length_ff) begin
               crc_in = crc_fed;
               emit   = 1'b1;
            end else if (idx == length_ff) begin
               crc_rx_in = req_tdata;
            end
         end
         position_in = position_ff + 8'd1;
      end else begin
         overflow_in = 1'b1;
      end

      byte_count     = {1'b0, position_ff} + 9'd1;
      expected_count = {1'b0, length_in} + MinFrameBytes;
      if (over) begin
         status = STATUS_LENGTH;
      end else if (byte_count < MinFrameBytes) begin
         status = STATUS_SHORT;
      end else if (header_err_in) begin
         status = STATUS_HEADER;
      end else if (code_err_in) begin
         status = STATUS_CODE;
      end else if (byte_count != expected_count) begin
         status = STATUS_LENGTH;
      end else if (req_tdata != trailer_ff) begin
         status = STATUS_TRAILER;
      end else if (crc_rx_in != crc_in) begin
         status = STATUS_CRC;
      end else begin
         status = STATUS_OK;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         if (req_tlast) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_STATUS;
            rsp_data_in  = {5'd0, status, length_in, code_in, 8'd0, 8'd0};
         end else if (emit) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_PAYLOAD;
            rsp_data_in  = {5'd0, STATUS_OK, length_in, code_in, idx, req_tdata};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         crc_ff        <= '0;
         code_ff       <= '0;
         length_ff     <= '0;
         crc_rx_ff     <= '0;
         header_err_ff <= 1'b0;
         code_err_ff   <= 1'b0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_tlast) begin
               position_ff   <= '0;
               crc_ff        <= '0;
               code_ff       <= '0;
               length_ff     <= '0;
               crc_rx_ff     <= '0;
               header_err_ff <= 1'b0;
               code_err_ff   <= 1'b0;
               overflow_ff   <= 1'b0;
            end else begin
               position_ff   <= position_in;
               crc_ff        <= crc_in;
               code_ff       <= code_in;
               length_ff     <= length_in;
               crc_rx_ff     <= crc_rx_in;
               header_err_ff <= header_err_in;
               code_err_ff   <= code_err_in;
               overflow_ff   <= overflow_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_last_restarts_frame: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> position_ff == '0 && !overflow_ff && crc_ff == '0)
      else $error("Frame state not cleared after the final byte.");

   a_payload_has_no_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_PAYLOAD |->
         rsp_data_ff[34:32] == STATUS_OK && rsp_data_ff[15:8] < rsp_data_ff[31:24])
      else $error("Payload transaction carries a status or an index beyond the length.");

   a_overflow_at_limit: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> position_ff == PosMax)
      else $error("Overflow flag set before the position counter saturated.");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the CRC-8 frame deframer with a frame-level predictor.
`timescale 1ns / 1ps

module tb_top;
   import crc8df_pkg::*;

   localparam logic [CsrAddrWidth-1:0] CsrSpareLow  = 3'd6;
   localparam logic [CsrAddrWidth-1:0] CsrSpareHigh = 3'd7;
   localparam int DrainCycles   = 4;
   localparam int TailCycles    = 8;
   localparam int HoldCycles    = 300;
   localparam int WatchdogLimit = 2000;

   class frame_checker;
      typedef struct {
         kind_type             kind;
         logic [ByteWidth-1:0] data;
         logic [ByteWidth-1:0] index;
         logic [ByteWidth-1:0] code;
         logic [ByteWidth-1:0] length;
         status_type           status;
      } rsp_item_type;

      logic [ByteWidth-1:0] hdr_first, hdr_second, trailer, code_req, code_cmd, poly;
      logic [ByteWidth-1:0] pos, crc, code_q, len_q, crc_rx;
      bit                   hdr_err, code_err, overflow;
      rsp_item_type         rsp_due_q[$];
      int                   errors;

      function void clear_frame();
         pos      = '0;
         crc      = '0;
         code_q   = '0;
         len_q    = '0;
         crc_rx   = '0;
         hdr_err  = 1'b0;
         code_err = 1'b0;
         overflow = 1'b0;
      endfunction

      function void restore_defaults();
         hdr_first  = HeaderFirstReset;
         hdr_second = HeaderSecondReset;
         trailer    = TrailerReset;
         code_req   = CodeRequestReset;
         code_cmd   = CodeCommandReset;
         poly       = CrcPolyReset;
         errors     = 0;
         clear_frame();
      endfunction

      function void set_reg(logic [CsrAddrWidth-1:0] idx, logic [ByteWidth-1:0] value);
         case (idx)
            CSR_HEADER_FIRST:  hdr_first  = value;
            CSR_HEADER_SECOND: hdr_second = value;
            CSR_TRAILER:       trailer    = value;
            CSR_CODE_REQUEST:  code_req   = value;
            CSR_CODE_COMMAND:  code_cmd   = value;
            CSR_CRC_POLY:      poly       = value;
            default: ;
         endcase
      endfunction

      function logic [ByteWidth-1:0] crc_byte(logic [ByteWidth-1:0] c, logic [ByteWidth-1:0] b);
         logic [ByteWidth-1:0] r;
         r = c ^ b;
         for (int k = 0; k < ByteWidth; k++) begin
            r = r[ByteWidth-1] ? ((r << 1) ^ poly) : (r << 1);
         end
         return r;
      endfunction

      function void note_byte(logic [ByteWidth-1:0] b, logic last_flag);
         logic [ByteWidth-1:0] p;
         logic [ByteWidth-1:0] idx;
         bit                   over;
         bit                   emit;
         int                   n;
         status_type           st;
         rsp_item_type         item;
         p    = pos;
         over = overflow || (p == PosMax);
         emit = 1'b0;
         idx  = '0;
         if (!over) begin
            if (p == PosHeaderFirst && b != hdr_first) hdr_err = 1'b1;
            if (p == PosHeaderSecond && b != hdr_second) hdr_err = 1'b1;
            if (p == PosCode) begin
               code_q = b;
               if (b != code_req && b != code_cmd) code_err = 1'b1;
            end
            if (p == PosLength) len_q = b;
            if (p < PosPayload) begin
               crc = crc_byte(crc, b);
            end else begin
               idx = p - PosPayload;
               if (idx < len_q) begin
                  crc  = crc_byte(crc, b);
                  emit = 1'b1;
               end else if (idx == len_q) begin
                  crc_rx = b;
               end
            end
            pos = p + 8'd1;
         end else begin
            overflow = 1'b1;
         end
         item.kind   = KIND_PAYLOAD;
         item.data   = '0;
         item.index  = '0;
         item.code   = code_q;
         item.length = len_q;
         item.status = STATUS_OK;
         if (last_flag) begin
            n = int'(p) + 1;
            if (over) st = STATUS_LENGTH;
            else if (n < int'(MinFrameBytes)) st = STATUS_SHORT;
            else if (hdr_err) st = STATUS_HEADER;
            else if (code_err) st = STATUS_CODE;
            else if (n != int'(len_q) + int'(MinFrameBytes)) st = STATUS_LENGTH;
            else if (b != trailer) st = STATUS_TRAILER;
            else if (crc_rx != crc) st = STATUS_CRC;
            else st = STATUS_OK;
            item.kind   = KIND_STATUS;
            item.status = st;
            rsp_due_q.push_back(item);
            clear_frame();
         end else if (emit) begin
            item.data  = b;
            item.index = idx;
            rsp_due_q.push_back(item);
         end
      endfunction

      function void check_rsp(logic [RspDataWidth-1:0] tdata, logic tuser);
         rsp_item_type want;
         bit           bad;
         if (rsp_due_q.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected result: tdata=%h tuser=%b", tdata, tuser);
            end
            return;
         end
         want = rsp_due_q.pop_front();
         bad = (tuser !== want.kind) || (tdata[7:0] !== want.data) ||
               (tdata[15:8] !== want.index) || (tdata[23:16] !== want.code) ||
               (tdata[31:24] !== want.length) || (tdata[34:32] !== want.status) ||
               (tdata[39:35] !== 5'd0);
         if (bad) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: expected kind=%0d byte=%h index=%0d code=%h len=%0d st=%0d",
                        want.kind, want.data, want.index, want.code, want.length,
                        want.status);
               $display("  actual kind=%0d byte=%h index=%0d code=%h len=%0d st=%0d pad=%h",
                        tuser, tdata[7:0], tdata[15:8], tdata[23:16], tdata[31:24],
                        tdata[34:32], tdata[39:35]);
            end
         end
      endfunction

      function int outstanding();
         return rsp_due_q.size();
      endfunction

      function void final_check();
         if (rsp_due_q.size() != 0) begin
            errors++;
            if (errors <= 10) begin
               $display("%0d expected results never arrived", rsp_due_q.size());
            end
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ByteWidth-1:0]    req_tdata = '0;
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_wen = 1'b0;
   logic [CsrAddrWidth-1:0] csr_addr = '0;
   logic [ByteWidth-1:0]    csr_wdata = '0;

   frame_checker         chk;
   logic [ByteWidth-1:0] frame_q[$];
   bit                   req_burst = 1'b0;
   bit                   hold_req = 1'b0;
   int                   items_sent = 0;
   int                   idle_cycles = 0;

   crc8_frame_deframer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [ByteWidth-1:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_byte(input logic [ByteWidth-1:0] b, input logic last_flag);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last_flag;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      chk.note_byte(b, last_flag);
   endtask

   task automatic send_frame();
      req_burst = ($urandom_range(0, 4) == 0);
      foreach (frame_q[i]) begin
         send_byte(frame_q[i], i == frame_q.size() - 1);
      end
      items_sent += frame_q.size();
   endtask

   task automatic start_frame(input logic [ByteWidth-1:0] code, input logic [ByteWidth-1:0] len);
      frame_q.delete();
      frame_q.push_back(chk.hdr_first);
      frame_q.push_back(chk.hdr_second);
      frame_q.push_back(code);
      frame_q.push_back(len);
   endtask

   task automatic finish_frame();
      logic [ByteWidth-1:0] c;
      c = '0;
      foreach (frame_q[i]) c = chk.crc_byte(c, frame_q[i]);
      frame_q.push_back(c);
      frame_q.push_back(chk.trailer);
   endtask

   task automatic send_random_frame(input int sel);
      int                   len;
      int                   cut;
      int                   total;
      logic [ByteWidth-1:0] v;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 60) : $urandom_range(0, 15);
      start_frame($urandom_range(0, 1) ? chk.code_req : chk.code_cmd, 8'(len));
      repeat (len) frame_q.push_back(rand_byte());
      finish_frame();
      if (sel < 55) begin
      end else if (sel < 62) begin
         frame_q[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      end else if (sel < 68) begin
         v = rand_byte();
         while (v == chk.code_req || v == chk.code_cmd) v = rand_byte();
         frame_q[2] = v;
      end else if (sel < 74) begin
         frame_q[frame_q.size() - 2] ^= 8'($urandom_range(1, 255));
      end else if (sel < 80) begin
         frame_q[frame_q.size() - 1] ^= 8'($urandom_range(1, 255));
      end else if (sel < 84) begin
         repeat ($urandom_range(1, 3)) frame_q.insert(frame_q.size() - 1, rand_byte());
      end else if (sel < 88) begin
         cut = $urandom_range(1, frame_q.size() - 1);
         while (frame_q.size() > cut) frame_q.pop_back();
      end else if (sel < 94) begin
         cut = $urandom_range(1, 5);
         while (frame_q.size() > cut) frame_q.pop_back();
      end else if (sel < 98) begin
         frame_q.delete();
         repeat ($urandom_range(1, 20)) frame_q.push_back(rand_byte());
      end else begin
         start_frame(chk.code_req, PosMax);
         total = $urandom_range(256, 264);
         while (frame_q.size() < total) frame_q.push_back(rand_byte());
      end
      send_frame();
   endtask

   task automatic run_random(input int target);
      items_sent = 0;
      while (items_sent < target) send_random_frame($urandom_range(0, 97));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (chk.outstanding() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrAddrWidth-1:0] idx, input logic [ByteWidth-1:0] value);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      chk.set_reg(idx, value);
   endtask

   task automatic apply_config(input logic [ByteWidth-1:0] hf, input logic [ByteWidth-1:0] hs,
                               input logic [ByteWidth-1:0] tr, input logic [ByteWidth-1:0] cr,
                               input logic [ByteWidth-1:0] cc, input logic [ByteWidth-1:0] pl);
      csr_write(CSR_HEADER_FIRST, hf);
      csr_write(CSR_HEADER_SECOND, hs);
      csr_write(CSR_TRAILER, tr);
      csr_write(CSR_CODE_REQUEST, cr);
      csr_write(CSR_CODE_COMMAND, cc);
      csr_write(CSR_CRC_POLY, pl);
      csr_write(CsrSpareLow, rand_byte());
      csr_write(CsrSpareHigh, rand_byte());
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) chk.check_rsp(rsp_tdata, rsp_tuser);
   end

   always @(negedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   initial begin : rsp_side
      int stall;
      int served;
      bit burst;
      served = 0;
      burst  = 1'b0;
      wait (!reset);
      forever begin
         if (served % 32 == 0) burst = ($urandom_range(0, 3) == 0);
         stall = burst ? 0 : $urandom_range(0, 7);
         if (hold_req) begin
            hold_req = 1'b0;
            stall    = HoldCycles;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
         while (!rsp_tvalid) @(negedge clock);
         @(posedge clock);
         served++;
      end
   end

   initial begin : req_side
      chk = new;
      chk.restore_defaults();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      start_frame(chk.code_req, 8'd0);
      finish_frame();
      send_frame();
      start_frame(chk.code_cmd, 8'd2);
      frame_q.push_back(8'hFF);
      frame_q.push_back(8'h00);
      finish_frame();
      send_frame();
      frame_q.delete();
      frame_q.push_back(8'h00);
      send_frame();
      start_frame(chk.code_req, 8'd1);
      frame_q.push_back(8'h5A);
      finish_frame();
      frame_q[0] ^= 8'hFF;
      send_frame();
      run_random(25);
      wait_drained();

      apply_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      hold_req = 1'b1;
      run_random(20);
      wait_drained();

      apply_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      run_random(15);
      wait_drained();

      apply_config(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
      run_random(15);
      wait_drained();

      apply_config(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
      send_random_frame(99);
      run_random(5);
      wait_drained();

      apply_config(HeaderFirstReset, HeaderSecondReset, TrailerReset, CodeRequestReset,
                   CodeCommandReset, CrcPolyReset);
      run_random(15);
      wait_drained();
      repeat (TailCycles) @(posedge clock);

      chk.final_check();
      if (chk.errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/crc8df_pkg.sv
hdl/crc8_frame_deframer.sv
tb/tb_top.sv
